FILE: sv/rigid_body_euler_integrator_macros.svh
// assertion macros shared by the rigid body integrator rtl
`ifndef RIGID_BODY_EULER_INTEGRATOR_MACROS_SVH
`define RIGID_BODY_EULER_INTEGRATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define RBEI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RBEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rbei_pkg.sv
// types, constants and microcode for the rigid body integrator
package rbei_pkg;

    // fixed point format
    localparam int RBEI_FRAC_BITS = 16;
    localparam int STEP_BITS      = 16;
    localparam int OPND_W         = 33;
    localparam int PROD_W         = 64;
    localparam int WIDE_W         = 65;
    localparam int ADDR_W         = 4;

    // register reset values
    localparam logic [30:0] MASS_RECIP_RESET  = 31'd65536;
    localparam logic [30:0] INV_INERTIA_RESET = 31'd65536;
    localparam logic [15:0] TIME_STEP_RESET   = 16'd1092;

    // saturation limits on the wide datapath
    localparam logic signed [WIDE_W-1:0] S32_MAX_W = 65'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN_W = -65'sd2147483648;

    // register indexes
    typedef enum logic [1:0] {
        REG_MASS_RECIP  = 2'd0,
        REG_INV_INERTIA = 2'd1,
        REG_TIME_STEP   = 2'd2
    } t_reg_idx;

    // operation codes
    typedef enum logic [2:0] {
        OP_FULL    = 3'd0,
        OP_FORCE   = 3'd1,
        OP_VEL     = 3'd2,
        OP_IMPULSE = 3'd3,
        OP_PLACE   = 3'd4
    } t_op;

    // multiplier operand sources
    typedef enum logic [3:0] {
        SA_VEC_X   = 4'd0,
        SA_VEC_Y   = 4'd1,
        SA_SCALAR  = 4'd2,
        SA_LEVER_X = 4'd3,
        SA_LEVER_Y = 4'd4,
        SA_TEMP    = 4'd5,
        SA_VEL_X   = 4'd6,
        SA_VEL_Y   = 4'd7,
        SA_SPIN    = 4'd8
    } t_src_a;

    typedef enum logic [2:0] {
        SB_MASS_RECIP  = 3'd0,
        SB_INV_INERTIA = 3'd1,
        SB_TIME_STEP   = 3'd2,
        SB_VEC_X       = 3'd3,
        SB_VEC_Y       = 3'd4
    } t_src_b;

    // where a scaled product goes
    typedef enum logic [3:0] {
        DST_TEMP    = 4'd0,
        DST_HOLD    = 4'd1,
        DST_CROSS   = 4'd2,
        DST_VEL_X   = 4'd3,
        DST_VEL_Y   = 4'd4,
        DST_SPIN    = 4'd5,
        DST_POS_X   = 4'd6,
        DST_POS_Y   = 4'd7,
        DST_HEADING = 4'd8
    } t_dst;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_src_a a_sel;
        t_src_b b_sel;
        logic   shift_dt;
        t_dst   dst;
        logic   last;
    } t_uop;

    // program entry points
    localparam t_step STEP_FULL_FIRST = 4'd0;
    localparam t_step STEP_FORCE_LAST = 4'd5;
    localparam t_step STEP_VEL_FIRST  = 4'd6;
    localparam t_step STEP_IMP_FIRST  = 4'd9;
    localparam t_step STEP_LAST       = 4'd13;

    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } t_sat;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
    } t_body;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] scalar;
        logic signed [31:0] lever_x;
        logic signed [31:0] lever_y;
    } t_item;

    // clip a wide signed value to 32 bits
    function automatic t_sat rbei_sat32(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        r.clip = 1'b0;
        r.val  = v[31:0];
        if (v > S32_MAX_W) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN_W) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end
        return r;
    endfunction

    // microcode: force part, velocity part, impulse part
    function automatic t_uop rbei_uop(input t_step step);
        t_uop u;
        u = '{SA_TEMP, SB_TIME_STEP, 1'b1, DST_TEMP, 1'b1};
        case (step)
            4'd0:  u = '{SA_VEC_X,   SB_MASS_RECIP,  1'b0, DST_TEMP,    1'b0};
            4'd1:  u = '{SA_TEMP,    SB_TIME_STEP,   1'b1, DST_VEL_X,   1'b0};
            4'd2:  u = '{SA_VEC_Y,   SB_MASS_RECIP,  1'b0, DST_TEMP,    1'b0};
            4'd3:  u = '{SA_TEMP,    SB_TIME_STEP,   1'b1, DST_VEL_Y,   1'b0};
            4'd4:  u = '{SA_SCALAR,  SB_INV_INERTIA, 1'b0, DST_TEMP,    1'b0};
            4'd5:  u = '{SA_TEMP,    SB_TIME_STEP,   1'b1, DST_SPIN,    1'b0};
            4'd6:  u = '{SA_VEL_X,   SB_TIME_STEP,   1'b1, DST_POS_X,   1'b0};
            4'd7:  u = '{SA_VEL_Y,   SB_TIME_STEP,   1'b1, DST_POS_Y,   1'b0};
            4'd8:  u = '{SA_SPIN,    SB_TIME_STEP,   1'b1, DST_HEADING, 1'b1};
            4'd9:  u = '{SA_LEVER_X, SB_VEC_Y,       1'b0, DST_HOLD,    1'b0};
            4'd10: u = '{SA_LEVER_Y, SB_VEC_X,       1'b0, DST_CROSS,   1'b0};
            4'd11: u = '{SA_TEMP,    SB_INV_INERTIA, 1'b0, DST_SPIN,    1'b0};
            4'd12: u = '{SA_VEC_X,   SB_MASS_RECIP,  1'b0, DST_VEL_X,   1'b0};
            4'd13: u = '{SA_VEC_Y,   SB_MASS_RECIP,  1'b0, DST_VEL_Y,   1'b1};
            default: u = '{SA_TEMP, SB_TIME_STEP, 1'b1, DST_TEMP, 1'b1};
        endcase
        return u;
    endfunction

endpackage

FILE: sv/rbei_mul.sv
// shared signed multiplier with registered product
module rbei_mul
    import rbei_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [2*OPND_W-1:0] w_full;
    logic signed [PROD_W-1:0]   r_prod;

    // operands never exceed 32 significant bits, so 64 product bits suffice
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/rbei_cfg.sv
// apb register file: inverse mass, inverse inertia, time step
module rbei_cfg
    import rbei_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [30:0]       o_mass_recip,
    output logic [30:0]       o_inv_inertia,
    output logic [15:0]       o_time_step
);

    logic [30:0] r_mass_recip;
    logic [30:0] r_inv_inertia;
    logic [15:0] r_time_step;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_recip  <= MASS_RECIP_RESET;
            r_inv_inertia <= INV_INERTIA_RESET;
            r_time_step   <= TIME_STEP_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MASS_RECIP:  r_mass_recip  <= pwdata[30:0];
                REG_INV_INERTIA: r_inv_inertia <= pwdata[30:0];
                REG_TIME_STEP:   r_time_step   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_MASS_RECIP:  prdata = {1'b0, r_mass_recip};
            REG_INV_INERTIA: prdata = {1'b0, r_inv_inertia};
            REG_TIME_STEP:   prdata = {16'd0, r_time_step};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_mass_recip  = r_mass_recip;
    assign o_inv_inertia = r_inv_inertia;
    assign o_time_step   = r_time_step;

endmodule

FILE: sv/rigid_body_euler_integrator.sv
// 2d rigid body semi-implicit euler integrator, top level
//
// usage: one body state (position, heading, velocity, spin, all signed Q16.16)
// lives in the block. each input beat on s_axis carries an operation in tuser
// and its operands in tdata; each accepted beat yields exactly one output beat
// on m_axis with the whole state after the operation plus the static and
// saturation flags. the apb port sets inverse mass, inverse inertia and the
// time step; write it only while the block is idle.
// all products go through one shared multiplier under a microcoded sequencer,
// each product in a multiply state, then a scale, clip and accumulate state.
// s_axis_tready is high only while the sequencer is idle; the next beat can
// be taken in the cycle after the result is loaded into the output register.
// reset clears the body state to zero and loads the register defaults.
// if m_axis stalls the result waits in the output register; a finished item
// holds in the done state until the output register is free.
`include "rigid_body_euler_integrator_macros.svh"

module rigid_body_euler_integrator
    import rbei_pkg::*;
#(
    parameter int FRAC_BITS = RBEI_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: vec_x[31:0], vec_y[63:32], scalar_in[95:64], lever_x[127:96],
    // lever_y[159:128]
    input  logic [159:0]      s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]        s_axis_tuser,
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata: position_x_out[31:0], position_y_out[63:32], angle_out[95:64],
    // velocity_x_out[127:96], velocity_y_out[159:128], spin_out[191:160]
    output logic [191:0]      m_axis_tdata,
    // tuser: is_static[0], saturated[1]
    output logic [1:0]        m_axis_tuser,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    t_op    r_op, n_op;
    t_item  r_item, n_item;
    t_body  r_body, n_body;
    logic   r_static, n_static;
    logic   r_sat, n_sat;
    logic signed [31:0]       r_temp, n_temp;
    logic signed [PROD_W-1:0] r_hold, n_hold;
    logic   r_out_valid, n_out_valid;
    logic [191:0] r_out_data, n_out_data;
    logic [1:0]   r_out_user, n_out_user;

    logic [30:0] w_mass_recip;
    logic [30:0] w_inv_inertia;
    logic [15:0] w_time_step;
    t_uop        w_uop;
    logic        w_mul_en;
    logic signed [31:0]       w_a32;
    logic signed [OPND_W-1:0] w_a;
    logic signed [OPND_W-1:0] w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [WIDE_W-1:0] w_p65;
    logic signed [WIDE_W-1:0] w_h65;
    logic signed [WIDE_W-1:0] w_src;
    logic signed [31:0]       w_old;
    logic signed [WIDE_W-1:0] w_sum;
    t_sat w_t;
    t_sat w_s;
    logic w_is_add;
    logic w_last;
    logic w_in_acc;

    // configuration registers
    rbei_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mass_recip  (w_mass_recip),
        .o_inv_inertia (w_inv_inertia),
        .o_time_step   (w_time_step)
    );

    assign w_uop    = rbei_uop(r_step);
    assign w_mul_en = (r_state == ST_MUL);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // operand a select
    always_comb begin
        case (w_uop.a_sel)
            SA_VEC_X:   w_a32 = r_item.vec_x;
            SA_VEC_Y:   w_a32 = r_item.vec_y;
            SA_SCALAR:  w_a32 = r_item.scalar;
            SA_LEVER_X: w_a32 = r_item.lever_x;
            SA_LEVER_Y: w_a32 = r_item.lever_y;
            SA_TEMP:    w_a32 = r_temp;
            SA_VEL_X:   w_a32 = r_body.vel_x;
            SA_VEL_Y:   w_a32 = r_body.vel_y;
            SA_SPIN:    w_a32 = r_body.spin;
            default:    w_a32 = r_temp;
        endcase
    end
    assign w_a = {w_a32[31], w_a32};

    // operand b select: config values are unsigned, vector parts signed
    always_comb begin
        case (w_uop.b_sel)
            SB_MASS_RECIP:  w_b = {2'b00, w_mass_recip};
            SB_INV_INERTIA: w_b = {2'b00, w_inv_inertia};
            SB_TIME_STEP:   w_b = {17'd0, w_time_step};
            SB_VEC_X:       w_b = {r_item.vec_x[31], r_item.vec_x};
            SB_VEC_Y:       w_b = {r_item.vec_y[31], r_item.vec_y};
            default:        w_b = {17'd0, w_time_step};
        endcase
    end

    // shared multiplier
    rbei_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // scale, clip and accumulate the registered product
    always_comb begin
        w_p65 = {w_prod[PROD_W-1], w_prod};
        w_h65 = {r_hold[PROD_W-1], r_hold};
        if (w_uop.dst == DST_CROSS) begin
            w_src = (w_h65 - w_p65) >>> FRAC_BITS;
        end else if (w_uop.shift_dt) begin
            w_src = w_p65 >>> STEP_BITS;
        end else begin
            w_src = w_p65 >>> FRAC_BITS;
        end
        w_t = rbei_sat32(w_src);
        w_is_add = 1'b1;
        case (w_uop.dst)
            DST_VEL_X:   w_old = r_body.vel_x;
            DST_VEL_Y:   w_old = r_body.vel_y;
            DST_SPIN:    w_old = r_body.spin;
            DST_POS_X:   w_old = r_body.pos_x;
            DST_POS_Y:   w_old = r_body.pos_y;
            DST_HEADING: w_old = r_body.heading;
            default: begin
                w_old    = 32'sd0;
                w_is_add = 1'b0;
            end
        endcase
        w_sum = {{33{w_old[31]}}, w_old} + {{33{w_t.val[31]}}, w_t.val};
        w_s   = rbei_sat32(w_sum);
    end

    // a force step stops after the force part of the program
    assign w_last = w_uop.last || ((r_op == OP_FORCE) && (r_step == STEP_FORCE_LAST));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_op        = r_op;
        n_item      = r_item;
        n_body      = r_body;
        n_static    = r_static;
        n_sat       = r_sat;
        n_temp      = r_temp;
        n_hold      = r_hold;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        // output register drains independently
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_item.vec_x   = s_axis_tdata[31:0];
                    n_item.vec_y   = s_axis_tdata[63:32];
                    n_item.scalar  = s_axis_tdata[95:64];
                    n_item.lever_x = s_axis_tdata[127:96];
                    n_item.lever_y = s_axis_tdata[159:128];
                    n_op     = t_op'(s_axis_tuser);
                    n_sat    = 1'b0;
                    n_static = 1'b0;
                    n_state  = ST_DONE;
                    case (t_op'(s_axis_tuser))
                        OP_FULL, OP_FORCE, OP_VEL, OP_IMPULSE: begin
                            if (w_mass_recip == 31'd0) begin
                                n_static = 1'b1;
                            end else begin
                                n_state = ST_MUL;
                                case (t_op'(s_axis_tuser))
                                    OP_VEL:     n_step = STEP_VEL_FIRST;
                                    OP_IMPULSE: n_step = STEP_IMP_FIRST;
                                    default:    n_step = STEP_FULL_FIRST;
                                endcase
                            end
                        end
                        OP_PLACE: begin
                            n_body.pos_x   = s_axis_tdata[31:0];
                            n_body.pos_y   = s_axis_tdata[63:32];
                            n_body.heading = s_axis_tdata[95:64];
                            n_body.vel_x   = 32'sd0;
                            n_body.vel_y   = 32'sd0;
                            n_body.spin    = 32'sd0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                case (w_uop.dst)
                    DST_TEMP:    n_temp = w_t.val;
                    DST_CROSS:   n_temp = w_t.val;
                    DST_HOLD:    n_hold = w_prod;
                    DST_VEL_X:   n_body.vel_x   = w_s.val;
                    DST_VEL_Y:   n_body.vel_y   = w_s.val;
                    DST_SPIN:    n_body.spin    = w_s.val;
                    DST_POS_X:   n_body.pos_x   = w_s.val;
                    DST_POS_Y:   n_body.pos_y   = w_s.val;
                    DST_HEADING: n_body.heading = w_s.val;
                    default: ;
                endcase
                // the held partial product is never clipped
                if (w_uop.dst != DST_HOLD) begin
                    n_sat = r_sat | w_t.clip | (w_is_add & w_s.clip);
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_body.spin, r_body.vel_y, r_body.vel_x,
                                   r_body.heading, r_body.pos_y, r_body.pos_x};
                    n_out_user  = {r_sat, r_static};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_FULL_FIRST;
            r_op        <= OP_FULL;
            r_body      <= '0;
            r_static    <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_op        <= n_op;
            r_body      <= n_body;
            r_static    <= n_static;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_temp     <= n_temp;
        r_hold     <= n_hold;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // checks
    `RBEI_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != ST_IDLE, "accepted beat did not start the sequencer")
    `RBEI_ASSERT_IMPLY(a_acc_after_mul, i_clk, i_rst_n, r_state == ST_ACC, $past(r_state == ST_MUL), "accumulate step without a multiply before it")
    `RBEI_ASSERT_IMPLY(a_static_no_clip, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "static body reported as saturated")
    `RBEI_ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, (r_state == ST_DONE) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && (r_state == ST_IDLE), "finished item not moved to the output register")

endmodule
